/* rtl/priority_deadline_retry_scheduler_macros.svh */
// Assertion helpers shared by the scheduler RTL.
`ifndef PRIORITY_DEADLINE_RETRY_SCHEDULER_MACROS_SVH
`define PRIORITY_DEADLINE_RETRY_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pdrs_pkg.sv */
`timescale 1ns / 1ps

package pdrs_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int DEADLINE_BITS_DEF = 32;

    localparam int ID_W   = 16;
    localparam int CNT_W  = 16;
    localparam int PRIO_W = 2;
    localparam int ATT_W  = 4;
    localparam int WGT_W  = 4;

    localparam logic [ATT_W-1:0] ATT_MAX = 4'd15;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_RUN    = 1'b1;

    localparam logic [PRIO_W-1:0] PRIO_LOW      = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_NORMAL   = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_HIGH     = 2'd2;
    localparam logic [PRIO_W-1:0] PRIO_CRITICAL = 2'd3;

    localparam logic [WGT_W-1:0] WGT_LOW      = 4'd1;
    localparam logic [WGT_W-1:0] WGT_NORMAL   = 4'd5;
    localparam logic [WGT_W-1:0] WGT_HIGH     = 4'd7;
    localparam logic [WGT_W-1:0] WGT_CRITICAL = 4'd10;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DONE     = 3'd3,
        ST_RETRY    = 3'd4,
        ST_DEAD     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_SCAN,
        S_RUN_SCAN,
        S_RUN_DRAIN,
        S_RUN_WRITE,
        S_RESULT
    } state_t;

    // picker control from the sequencer
    typedef struct packed {
        logic clear;
        logic cand_en;
    } pick_ctl_t;

    function automatic logic [WGT_W-1:0] prio_weight(input logic [PRIO_W-1:0] code);
        logic [WGT_W-1:0] w;
        unique case (code)
            PRIO_LOW:      w = WGT_LOW;
            PRIO_NORMAL:   w = WGT_NORMAL;
            PRIO_HIGH:     w = WGT_HIGH;
            PRIO_CRITICAL: w = WGT_CRITICAL;
            default:       w = WGT_LOW;
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* rtl/priority_deadline_retry_scheduler.sv */
// Sequence: a full or empty answer goes straight to the result; a submit first scans for a free slot;
// a run does one task-memory read per entry, then drain, write back and result.
// One item at a time: in_stall holds new requests until the result is loaded, and a run's length
// is set by the single read port of the task memory walked once per run.
// Reset (rst_n, async low): all entries invalid, next id 1, all counters zero.
`timescale 1ns / 1ps
`include "priority_deadline_retry_scheduler_macros.svh"

module priority_deadline_retry_scheduler #(
    parameter int QUEUE_DEPTH   = pdrs_pkg::QUEUE_DEPTH_DEF,
    parameter int DEADLINE_BITS = pdrs_pkg::DEADLINE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [pdrs_pkg::PRIO_W-1:0] priority_req,
    input  logic [31:0]                 deadline,
    input  logic [pdrs_pkg::ATT_W-1:0]  attempt_limit,
    input  logic                        outcome,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [pdrs_pkg::ID_W-1:0]   task_id,
    output logic [pdrs_pkg::ATT_W-1:0]  attempt,
    output logic [pdrs_pkg::CNT_W-1:0]  submitted_count,
    output logic [pdrs_pkg::CNT_W-1:0]  succeeded_count,
    output logic [pdrs_pkg::CNT_W-1:0]  dead_count
);

    import pdrs_pkg::*;

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DL_W    = DEADLINE_BITS;
    // entry layout, LSB first: max attempts, attempt, deadline, priority, id
    localparam int ATT_LO  = ATT_W;
    localparam int DL_LO   = 2 * ATT_W;
    localparam int PRIO_LO = DL_LO + DL_W;
    localparam int ID_LO   = PRIO_LO + PRIO_W;
    localparam int ENTRY_W = ID_LO + ID_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [QUEUE_DEPTH-1:0] valid_flags_reg, valid_flags_next;
    logic [QUEUE_DEPTH-1:0] deferred_flags_reg, deferred_flags_next;
    logic [ID_W-1:0]        next_id_reg, next_id_next;
    logic [CNT_W-1:0]       sub_cnt_reg, sub_cnt_next;
    logic [CNT_W-1:0]       succ_cnt_reg, succ_cnt_next;
    logic [CNT_W-1:0]       dead_cnt_reg, dead_cnt_next;

    // read pipeline: eligibility and index of the entry whose data is on the read port this cycle
    logic                   cmp_en_reg, cmp_en_next;
    logic [IDX_W-1:0]       cmp_idx_reg;

    // latched request fields
    logic [PRIO_W-1:0]      prio_reg;
    logic [DL_W-1:0]        dl_reg;
    logic [ATT_W-1:0]       max_reg;
    logic                   outcome_reg;

    // pending result
    status_t                res_status_reg, res_status_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic [ATT_W-1:0]       res_att_reg, res_att_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [ATT_W-1:0]       out_att_reg;
    logic [CNT_W-1:0]       out_sub_reg;
    logic [CNT_W-1:0]       out_succ_reg;
    logic [CNT_W-1:0]       out_dead_reg;
    logic                   out_load;

    logic                   in_accept;

    // memory ports
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]     mem_wdata;
    logic                   mem_re;
    logic [ENTRY_W-1:0]     mem_rdata;

    // picker
    pick_ctl_t              pick_ctl;
    logic                   have_best;
    logic [IDX_W-1:0]       best_idx;
    logic [ID_W-1:0]        best_id;
    logic [PRIO_W-1:0]      best_prio;
    logic [DL_W-1:0]        best_dl;
    logic [ATT_W-1:0]       best_att;
    logic [ATT_W-1:0]       best_max;
    logic [ATT_W-1:0]       att_new;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);

    // ---------------------------------------------------------------
    // Task payload memory; valid and deferred marks live in flops
    // ---------------------------------------------------------------
    pdrs_task_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    pdrs_picker #(
        .IDX_W (IDX_W),
        .DL_W  (DL_W)
    ) u_picker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pick_ctl),
        .cand_idx  (cmp_idx_reg),
        .cand_id   (mem_rdata[ID_LO +: ID_W]),
        .cand_prio (mem_rdata[PRIO_LO +: PRIO_W]),
        .cand_dl   (mem_rdata[DL_LO +: DL_W]),
        .cand_att  (mem_rdata[ATT_LO +: ATT_W]),
        .cand_max  (mem_rdata[ATT_W-1:0]),
        .have_best (have_best),
        .best_idx  (best_idx),
        .best_id   (best_id),
        .best_prio (best_prio),
        .best_dl   (best_dl),
        .best_att  (best_att),
        .best_max  (best_max)
    );

    assign att_new = (best_att == ATT_MAX) ? best_att : best_att + ATT_W'(1);

    // ---------------------------------------------------------------
    // Sequencer: next state, memory access, result formation
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        idx_next            = idx_reg;
        valid_flags_next    = valid_flags_reg;
        deferred_flags_next = deferred_flags_reg;
        next_id_next        = next_id_reg;
        sub_cnt_next        = sub_cnt_reg;
        succ_cnt_next       = succ_cnt_reg;
        dead_cnt_next       = dead_cnt_reg;
        res_status_next     = res_status_reg;
        res_id_next         = res_id_reg;
        res_att_next        = res_att_reg;
        cmp_en_next         = 1'b0;
        mem_we              = 1'b0;
        mem_waddr           = idx_reg;
        mem_wdata           = '0;
        mem_re              = 1'b0;
        pick_ctl.clear      = 1'b0;
        pick_ctl.cand_en    = cmp_en_reg;
        out_load            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_id_next  = '0;
                    res_att_next = '0;
                    idx_next     = '0;
                    if (kind == KIND_SUBMIT)
                    begin
                        if (&valid_flags_reg)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_FREE_SCAN;
                        end
                    end
                    else
                    begin
                        if (valid_flags_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            // nothing eligible: start a new round of retries
                            if ((valid_flags_reg & ~deferred_flags_reg) == '0)
                            begin
                                deferred_flags_next = '0;
                            end
                            pick_ctl.clear = 1'b1;
                            state_next     = S_RUN_SCAN;
                        end
                    end
                end
            end

            S_FREE_SCAN:
            begin
                if (!valid_flags_reg[idx_reg])
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {next_id_reg, prio_reg, dl_reg, {ATT_W{1'b0}}, max_reg};
                    valid_flags_next[idx_reg]    = 1'b1;
                    deferred_flags_next[idx_reg] = 1'b0;
                    res_status_next = ST_ACCEPTED;
                    res_id_next     = next_id_reg;
                    next_id_next    = next_id_reg + ID_W'(1);
                    sub_cnt_next    = sat_inc(sub_cnt_reg);
                    state_next      = S_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_RUN_SCAN:
            begin
                mem_re      = 1'b1;
                cmp_en_next = valid_flags_reg[idx_reg] && !deferred_flags_reg[idx_reg];
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_RUN_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_RUN_DRAIN:
            begin
                // last read is compared this cycle
                state_next = S_RUN_WRITE;
            end

            S_RUN_WRITE:
            begin
                mem_we       = 1'b1;
                mem_waddr    = best_idx;
                mem_wdata    = {best_id, best_prio, best_dl, att_new, best_max};
                res_id_next  = best_id;
                res_att_next = att_new;
                if (outcome_reg)
                begin
                    valid_flags_next[best_idx] = 1'b0;
                    succ_cnt_next   = sat_inc(succ_cnt_reg);
                    res_status_next = ST_DONE;
                end
                else if (att_new < best_max)
                begin
                    deferred_flags_next[best_idx] = 1'b1;
                    res_status_next = ST_RETRY;
                end
                else
                begin
                    valid_flags_next[best_idx] = 1'b0;
                    dead_cnt_next   = sat_inc(dead_cnt_reg);
                    res_status_next = ST_DEAD;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            idx_reg            <= '0;
            valid_flags_reg    <= '0;
            deferred_flags_reg <= '0;
            next_id_reg        <= ID_W'(1);
            sub_cnt_reg        <= '0;
            succ_cnt_reg       <= '0;
            dead_cnt_reg       <= '0;
            cmp_en_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            idx_reg            <= idx_next;
            valid_flags_reg    <= valid_flags_next;
            deferred_flags_reg <= deferred_flags_next;
            next_id_reg        <= next_id_next;
            sub_cnt_reg        <= sub_cnt_next;
            succ_cnt_reg       <= succ_cnt_next;
            dead_cnt_reg       <= dead_cnt_next;
            cmp_en_reg         <= cmp_en_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= idx_reg;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_att_reg    <= res_att_next;
        if (in_accept)
        begin
            prio_reg    <= priority_req;
            dl_reg      <= DL_W'(deadline);
            max_reg     <= attempt_limit;
            outcome_reg <= outcome;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_att_reg    <= res_att_reg;
            out_sub_reg    <= sub_cnt_reg;
            out_succ_reg   <= succ_cnt_reg;
            out_dead_reg   <= dead_cnt_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign task_id         = out_id_reg;
    assign attempt         = out_att_reg;
    assign submitted_count = out_sub_reg;
    assign succeeded_count = out_succ_reg;
    assign dead_count      = out_dead_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // an accepted transfer always starts work
    `PDRS_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_accept, state_reg != S_IDLE, "accepted transfer did not start work")
    // a run on a non-empty queue always finds a task after the round reset
    `PDRS_ASSERT_IMP(a_run_has_best, clk, rst_n, state_reg == S_RUN_WRITE, have_best, "run reached write back without a selected task")
    // the free-slot scan only starts when a slot exists
    `PDRS_ASSERT_IMP(a_free_slot_exists, clk, rst_n, state_reg == S_FREE_SCAN, !(&valid_flags_reg), "free-slot scan with a full queue")
    // a rejected or empty answer carries no id and no attempt
    `PDRS_ASSERT_IMP(a_reject_zero_fields, clk, rst_n, out_valid_reg && (out_status_reg == ST_FULL || out_status_reg == ST_EMPTY), (out_id_reg == '0) && (out_att_reg == '0), "full or empty result with nonzero id or attempt")

endmodule

/* rtl/pdrs_task_mem.sv */
`timescale 1ns / 1ps

module pdrs_task_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 58
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pdrs_picker.sv */
`timescale 1ns / 1ps

module pdrs_picker #(
    parameter int IDX_W = 4,
    parameter int DL_W  = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pdrs_pkg::pick_ctl_t       ctl,
    input  logic [IDX_W-1:0]          cand_idx,
    input  logic [pdrs_pkg::ID_W-1:0] cand_id,
    input  logic [pdrs_pkg::PRIO_W-1:0] cand_prio,
    input  logic [DL_W-1:0]           cand_dl,
    input  logic [pdrs_pkg::ATT_W-1:0] cand_att,
    input  logic [pdrs_pkg::ATT_W-1:0] cand_max,
    output logic                      have_best,
    output logic [IDX_W-1:0]          best_idx,
    output logic [pdrs_pkg::ID_W-1:0] best_id,
    output logic [pdrs_pkg::PRIO_W-1:0] best_prio,
    output logic [DL_W-1:0]           best_dl,
    output logic [pdrs_pkg::ATT_W-1:0] best_att,
    output logic [pdrs_pkg::ATT_W-1:0] best_max
);

    import pdrs_pkg::*;

    logic              have_best_reg;
    logic              have_best_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [DL_W-1:0]   best_dl_reg;
    logic [ATT_W-1:0]  best_att_reg;
    logic [ATT_W-1:0]  best_max_reg;

    logic [WGT_W-1:0]  w_cand;
    logic [WGT_W-1:0]  w_best;
    logic              better;
    logic              take;

    // priority weight, then earlier deadline, then lower id
    always_comb
    begin
        w_cand = prio_weight(cand_prio);
        w_best = prio_weight(best_prio_reg);
        if (w_cand != w_best)
        begin
            better = (w_cand > w_best);
        end
        else if (cand_dl != best_dl_reg)
        begin
            better = (cand_dl < best_dl_reg);
        end
        else
        begin
            better = (cand_id < best_id_reg);
        end
        take = ctl.cand_en && (!have_best_reg || better);
        if (ctl.clear)
        begin
            have_best_next = 1'b0;
        end
        else
        begin
            have_best_next = have_best_reg || take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
        end
        else
        begin
            have_best_reg <= have_best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg  <= cand_idx;
            best_id_reg   <= cand_id;
            best_prio_reg <= cand_prio;
            best_dl_reg   <= cand_dl;
            best_att_reg  <= cand_att;
            best_max_reg  <= cand_max;
        end
    end

    assign have_best = have_best_reg;
    assign best_idx  = best_idx_reg;
    assign best_id   = best_id_reg;
    assign best_prio = best_prio_reg;
    assign best_dl   = best_dl_reg;
    assign best_att  = best_att_reg;
    assign best_max  = best_max_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import pdrs_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;

    // one request transfer as offered on the input channel
    typedef struct {
        logic              kind;
        logic [PRIO_W-1:0] prio;
        logic [31:0]       deadline;
        logic [ATT_W-1:0]  max_att;
        logic              outcome;
    } sched_req_t;

    // one reply transfer as seen on the result channel
    typedef struct {
        status_t          status;
        logic [ID_W-1:0]  id;
        logic [ATT_W-1:0] att;
        logic [CNT_W-1:0] submitted;
        logic [CNT_W-1:0] succeeded;
        logic [CNT_W-1:0] dead;
    } sched_reply_t;

    // shadow copy of one task slot
    typedef struct {
        bit                valid;
        bit                deferred;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [31:0]       deadline;
        logic [ATT_W-1:0]  att;
        logic [ATT_W-1:0]  max_att;
    } task_slot_t;

    // Shadow scheduler: replays every accepted request on its own copy of the
    // task queue and keeps the replies that the block owes, oldest first.
    class sched_shadow;
        task_slot_t       slots[QDEPTH];
        logic [ID_W-1:0]  next_id;
        logic [CNT_W-1:0] n_submitted;
        logic [CNT_W-1:0] n_succeeded;
        logic [CNT_W-1:0] n_dead;
        sched_reply_t     replies_due[$];
        int               mismatches;

        function new();
            foreach (slots[i])
            begin
                slots[i].valid    = 1'b0;
                slots[i].deferred = 1'b0;
            end
            next_id     = ID_W'(1);
            n_submitted = '0;
            n_succeeded = '0;
            n_dead      = '0;
            mismatches  = 0;
        endfunction

        function int weight(logic [PRIO_W-1:0] p);
            case (p)
                PRIO_LOW:      return int'(WGT_LOW);
                PRIO_NORMAL:   return int'(WGT_NORMAL);
                PRIO_HIGH:     return int'(WGT_HIGH);
                default:       return int'(WGT_CRITICAL);
            endcase
        endfunction

        // priority weight, then earlier deadline, then lower id
        function bit outranks(task_slot_t a, task_slot_t b);
            if (weight(a.prio) != weight(b.prio))
                return weight(a.prio) > weight(b.prio);
            if (a.deadline != b.deadline)
                return a.deadline < b.deadline;
            return a.id < b.id;
        endfunction

        function int best_ready();
            int best;
            best = -1;
            for (int i = 0; i < QDEPTH; i++)
            begin
                if (slots[i].valid && !slots[i].deferred)
                    if (best < 0 || outranks(slots[i], slots[best]))
                        best = i;
            end
            return best;
        endfunction

        function void note_request(sched_req_t r);
            sched_reply_t rep;
            int           slot;
            rep.id  = '0;
            rep.att = '0;
            slot    = -1;
            if (r.kind == KIND_SUBMIT)
            begin
                for (int i = QDEPTH - 1; i >= 0; i--)
                    if (!slots[i].valid)
                        slot = i;
                if (slot < 0)
                    rep.status = ST_FULL;
                else
                begin
                    slots[slot].valid    = 1'b1;
                    slots[slot].deferred = 1'b0;
                    slots[slot].id       = next_id;
                    slots[slot].prio     = r.prio;
                    slots[slot].deadline = r.deadline;
                    slots[slot].att      = '0;
                    slots[slot].max_att  = r.max_att;
                    rep.id               = next_id;
                    rep.status           = ST_ACCEPTED;
                    next_id++;
                    if (n_submitted != CNT_MAX)
                        n_submitted++;
                end
            end
            else
            begin
                slot = best_ready();
                // round over: every deferred retry becomes eligible again
                if (slot < 0)
                begin
                    foreach (slots[i])
                        slots[i].deferred = 1'b0;
                    slot = best_ready();
                end
                if (slot < 0)
                    rep.status = ST_EMPTY;
                else
                begin
                    if (slots[slot].att != ATT_MAX)
                        slots[slot].att++;
                    rep.id  = slots[slot].id;
                    rep.att = slots[slot].att;
                    if (r.outcome)
                    begin
                        slots[slot].valid = 1'b0;
                        rep.status        = ST_DONE;
                        if (n_succeeded != CNT_MAX)
                            n_succeeded++;
                    end
                    else if (slots[slot].att < slots[slot].max_att)
                    begin
                        slots[slot].deferred = 1'b1;
                        rep.status           = ST_RETRY;
                    end
                    else
                    begin
                        slots[slot].valid = 1'b0;
                        rep.status        = ST_DEAD;
                        if (n_dead != CNT_MAX)
                            n_dead++;
                    end
                end
            end
            rep.submitted = n_submitted;
            rep.succeeded = n_succeeded;
            rep.dead      = n_dead;
            replies_due   = {replies_due, rep};
        endfunction

        function void check_result(sched_reply_t got);
            sched_reply_t want;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: st=%0d id=%0d att=%0d", got.status, got.id,
                             got.att);
                return;
            end
            want = replies_due.pop_front();
            if (got.status != want.status || got.id != want.id || got.att != want.att ||
                got.submitted != want.submitted || got.succeeded != want.succeeded ||
                got.dead != want.dead)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply mismatch: want st=%0d id=%0d att=%0d sub=%0d ok=%0d dead=%0d %s",
                             want.status, want.id, want.att, want.submitted, want.succeeded,
                             want.dead, "");
                if (mismatches <= 10)
                    $display("                got  st=%0d id=%0d att=%0d sub=%0d ok=%0d dead=%0d",
                             got.status, got.id, got.att, got.submitted, got.succeeded,
                             got.dead);
            end
        endfunction
    endclass

    // DUT-facing signals; the inputs are known from time zero
    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic                kind          = KIND_SUBMIT;
    logic [PRIO_W-1:0]   priority_req  = PRIO_LOW;
    logic [31:0]         deadline      = '0;
    logic [ATT_W-1:0]    attempt_limit = '0;
    logic                outcome       = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [2:0]          status;
    logic [ID_W-1:0]     task_id;
    logic [ATT_W-1:0]    attempt;
    logic [CNT_W-1:0]    submitted_count;
    logic [CNT_W-1:0]    succeeded_count;
    logic [CNT_W-1:0]    dead_count;

    // quiet: neither side idles; hold_req: ask the receiver for one long hold-off
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    sched_shadow shadow = new();

    priority_deadline_retry_scheduler i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length shared by both sides: mostly none, some short, a few long.
    function automatic int idle_len();
        int r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Fields the operation ignores are still randomized so their bits toggle.
    function automatic sched_req_t submit_req(logic [PRIO_W-1:0] p, logic [31:0] d,
                                              logic [ATT_W-1:0] m);
        sched_req_t r;
        r.kind     = KIND_SUBMIT;
        r.prio     = p;
        r.deadline = d;
        r.max_att  = m;
        r.outcome  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic sched_req_t run_req(logic ok);
        sched_req_t r;
        r.kind     = KIND_RUN;
        r.prio     = PRIO_W'($urandom_range(0, 3));
        r.deadline = $urandom();
        r.max_att  = ATT_W'($urandom_range(0, 15));
        r.outcome  = ok;
        return r;
    endfunction

    // Random submit. Deadlines often come from a tiny pool so priority ties
    // fall through to the deadline and id rules; attempt limits stay small
    // most of the time so retries and deaths are frequent.
    function automatic sched_req_t random_submit();
        logic [31:0]      d;
        logic [ATT_W-1:0] m;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = '1;
            2, 3, 4, 5: d = $urandom_range(0, 3);
            default: d = $urandom();
        endcase
        case ($urandom_range(0, 9))
            0:       m = '0;
            1:       m = ATT_MAX;
            2:       m = ATT_W'($urandom_range(0, 15));
            default: m = ATT_W'($urandom_range(1, 4));
        endcase
        return submit_req(PRIO_W'($urandom_range(0, 3)), d, m);
    endfunction

    // Offer one request and hold it until the transfer completes. Entered
    // and left just after a falling edge, so valid stays high between
    // back-to-back transfers with a single update per step.
    task automatic offer(input sched_req_t r);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind          <= r.kind;
        priority_req  <= r.prio;
        deadline      <= r.deadline;
        attempt_limit <= r.max_att;
        outcome       <= r.outcome;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        shadow.note_request(r);
        @(negedge clk);
    endtask

    // Sender pause: nothing offered until every owed reply has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (shadow.replies_due.size() != 0);
    endtask

    // Directed opening: empty run, a full fill covering every priority, both
    // deadline extremes, attempt limits zero through fifteen and equal
    // priority/deadline pairs, a submit into the full queue, then a mix of
    // failing and succeeding runs.
    task automatic directed_part();
        logic [PRIO_W-1:0] codes[4];
        logic [31:0]       d;
        codes = '{PRIO_LOW, PRIO_NORMAL, PRIO_HIGH, PRIO_CRITICAL};
        quiet = 1'b0;
        offer(run_req(1'b1));
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (i < 8)
                d = (i % 2 != 0) ? 32'hFFFF_FFFF : 32'h0;
            else
                d = 32'(i);
            offer(submit_req(codes[i % 4], d, ATT_W'(i)));
        end
        offer(submit_req(PRIO_CRITICAL, 32'h0, 4'd1));
        for (int i = 0; i < 6; i++)
            offer(run_req(i == 2 || i == 4));
    endtask

    // Random traffic in stretches of 100 transfers. Each stretch picks a
    // submit bias so the queue swings between empty and full, and about one
    // stretch in four runs with no idling on either side.
    task automatic random_part(input int n_items);
        int bias;
        bias = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       bias = 25;
                    1:       bias = 50;
                    default: bias = 75;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < bias)
                offer(random_submit());
            else
                offer(run_req($urandom_range(0, 9) < 4));
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        int waited;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_part();
        wait_drained();
        random_part(400);
        // result side holds off while requests keep coming: the block backs up
        hold_req = 1'b1;
        random_part(400);
        wait_drained();
        random_part(800);
        in_valid <= 1'b0;

        waited = 0;
        while (shadow.replies_due.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (shadow.replies_due.size() != 0)
            $display("%0d replies never arrived", shadow.replies_due.size());
        if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result-side stall generator, updated on the falling edge. A hold-off
    // request stalls while hold_left counts down here; otherwise random bursts,
    // none while quiet.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = 200;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Reply monitor: values sampled at the rising edge are the pre-edge ones.
    initial
    begin
        sched_reply_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.status    = status_t'(status);
                got.id        = task_id;
                got.att       = attempt;
                got.submitted = submitted_count;
                got.succeeded = succeeded_count;
                got.dead      = dead_count;
                shadow.check_result(got);
            end
        end
    end

    // Hard stop, several times the slowest legal run.
    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
